// File: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

   localparam int HEAP_BYTES      = 4096;
   localparam int HEADER_BYTES    = 16;
   localparam int MIN_SPLIT_BYTES = 16;
   localparam int INIT_CAP        = HEAP_BYTES - HEADER_BYTES;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic CSR_BASE_ADDRESS      = 1'b0;
   localparam logic CSR_INITIAL_FREE_SIZE = 1'b1;

   // controller states, also the step code handed to the datapath
   localparam logic [4:0] ST_INIT  = 5'd0;
   localparam logic [4:0] ST_CLR   = 5'd1;
   localparam logic [4:0] ST_IDLE  = 5'd2;
   localparam logic [4:0] ST_DISP  = 5'd3;
   localparam logic [4:0] ST_A_RD  = 5'd4;
   localparam logic [4:0] ST_A_CHK = 5'd5;
   localparam logic [4:0] ST_A_WQ  = 5'd6;
   localparam logic [4:0] ST_A_WP  = 5'd7;
   localparam logic [4:0] ST_L_RD  = 5'd8;
   localparam logic [4:0] ST_L_WR  = 5'd9;
   localparam logic [4:0] ST_R_RDC = 5'd10;
   localparam logic [4:0] ST_R_CHC = 5'd11;
   localparam logic [4:0] ST_R_RDB = 5'd12;
   localparam logic [4:0] ST_R_CHB = 5'd13;
   localparam logic [4:0] ST_R_NXT = 5'd14;
   localparam logic [4:0] ST_R_CHN = 5'd15;
   localparam logic [4:0] ST_R_WC  = 5'd16;
   localparam logic [4:0] ST_FAIL  = 5'd17;
   localparam logic [4:0] ST_OUT   = 5'd18;

   typedef struct packed {
      logic [11:0] link;
      logic        linked;
      logic        alloc;
      logic        more;
      logic [12:0] size;
   } hdr_type;

   typedef struct packed {
      logic        operation;
      logic [11:0] request_size;
      logic [31:0] release_address;
   } req_type;

   typedef struct packed {
      logic [31:0] payload_address;
      logic        granted;
   } rsp_type;

   typedef struct packed {
      logic [4:0] step;
      logic       mem_rd;
      logic       mem_wr;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic c_out;
      logic p_out;
      logic hit;
      logic rd_more;
      logic rd_alloc;
      logic rd_linked;
      logic split_ok;
      logic tfix;
      logic more_r;
      logic n_in;
      logic n2_in;
      logic clr_last;
   } sts_type;

endpackage
`default_nettype wire

// File: hw/rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator over a 4096-byte region with boundary-tag merging.
// req channel: req_valid/req_stall with req_data (operation, request_size,
//   release_address). A transaction is taken when valid is high and stall low.
// rsp channel: rsp_valid/rsp_stall with rsp_data (payload_address, granted);
//   exactly one response per request, in order.
// Allocate walks the chunk headers, one header memory read per visited chunk,
//   then writes the split-off free chunk when it splits and reads and rewrites
//   the following chunk's header when its back link must be repaired. A release
//   of an address outside the heap skips the header reads and is refused.
//   One request is in flight at a time; the next request is taken once the
//   previous result sits in the output register.
// Reset: controls clear and header entry 0 is written as one free chunk. A
//   CSR write (base_address at 0x0, initial_free_size at 0x4) clears all 4096
//   headers, one per cycle, then rebuilds the free chunk; req_stall stays
//   high during that clearing pass.
// When rsp_stall is high the held response stays stable and the block stops
//   after finishing the next request until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_top import ffha_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [31:0] base_ff, base_in;
   logic [11:0] ifs_ff, ifs_in;
   logic        wr_en, cfg_wr;
   cmd_type     cmd;
   sts_type     sts;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg_wr     = wr_en;
   assign csr_prdata = (csr_paddr[2] == CSR_INITIAL_FREE_SIZE) ? {20'b0, ifs_ff} : base_ff;

   always_comb begin
      base_in = base_ff;
      ifs_in  = ifs_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            CSR_BASE_ADDRESS:      base_in = csr_pwdata;
            CSR_INITIAL_FREE_SIZE: ifs_in  = csr_pwdata[11:0];
            default:               base_in = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         ifs_ff  <= 12'(INIT_CAP);
      end else begin
         base_ff <= base_in;
         ifs_ff  <= ifs_in;
      end
   end

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffha_dp u_dp (
      .clock             (clock),
      .base_address      (base_ff),
      .initial_free_size (ifs_ff),
      .req_data          (req_data),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_data          (rsp_data)
   );

endmodule
`default_nettype wire

// File: hw/rtl/ffha_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl import ffha_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cfg_wr,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_go;

   assign out_go    = (state_ff == ST_OUT) && !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != ST_IDLE) || cfg_wr;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.step     = state_ff;
      cmd.mem_rd   = 1'b0;
      cmd.mem_wr   = 1'b0;
      cmd.rsp_load = out_go;
      case (state_ff)
         ST_INIT: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_CLR: begin
            cmd.mem_wr = 1'b1;
            if (sts.clr_last) state_in = ST_INIT;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISP;
         end
         ST_DISP: begin
            if (sts.op == OP_ALLOC) state_in = ST_A_RD;
            else if (sts.c_out) state_in = ST_FAIL;
            else state_in = ST_R_RDC;
         end
         ST_A_RD: begin
            if (sts.p_out) state_in = ST_FAIL;
            else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_A_CHK;
            end
         end
         ST_A_CHK: begin
            if (sts.hit) state_in = sts.split_ok ? ST_A_WQ : ST_A_WP;
            else if (sts.rd_more) state_in = ST_A_RD;
            else state_in = ST_FAIL;
         end
         ST_A_WQ: begin
            cmd.mem_wr = 1'b1;
            state_in   = sts.tfix ? ST_L_RD : ST_A_WP;
         end
         ST_A_WP: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_OUT;
         end
         ST_L_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_L_WR;
         end
         ST_L_WR: begin
            cmd.mem_wr = 1'b1;
            state_in   = (sts.op == OP_ALLOC) ? ST_A_WP : ST_R_WC;
         end
         ST_R_RDC: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_R_CHC;
         end
         ST_R_CHC: begin
            state_in = sts.rd_linked ? ST_R_RDB : ST_R_NXT;
         end
         ST_R_RDB: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_R_CHB;
         end
         ST_R_CHB: begin
            state_in = ST_R_NXT;
         end
         ST_R_NXT: begin
            if (sts.more_r && sts.n_in) begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_R_CHN;
            end else begin
               state_in = ST_R_WC;
            end
         end
         ST_R_CHN: begin
            if (!sts.rd_alloc && sts.rd_more) state_in = sts.n2_in ? ST_L_RD : ST_R_WC;
            else state_in = ST_L_WR;
         end
         ST_R_WC: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_OUT;
         end
         ST_FAIL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
      if (cfg_wr) state_in = ST_CLR;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (out_go) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ffha_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_dp import ffha_pkg::*; (
   input  wire logic        clock,
   input  wire logic [31:0] base_address,
   input  wire logic [11:0] initial_free_size,
   input  wire req_type     req_data,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output rsp_type          rsp_data
);

   hdr_type mem [HEAP_BYTES];
   hdr_type rd_ff, h_ff;

   logic        op_ff, c_out_ff, split_ff, more_ff, lkd_ff, grant_ff;
   logic [11:0] req_ff, c_ff, lk_ff, naddr_ff, lnk_to_ff, clr_ff;
   logic [13:0] p_ff;
   logic [14:0] size_ff;
   logic [31:0] addr_ff;
   rsp_type     rsp_ff;

   logic [31:0] c32;
   logic [13:0] q, t;
   logic [15:0] n, n2;
   logic [12:0] sat, init_size, nsize;
   logic [14:0] size_b, size_n;
   logic [11:0] raddr, waddr;
   hdr_type     wdata;

   assign c32       = req_data.release_address - base_address - 32'(HEADER_BYTES);
   assign q         = p_ff + 14'(HEADER_BYTES) + {2'b0, req_ff};
   assign t         = p_ff + 14'(HEADER_BYTES) + {1'b0, h_ff.size};
   assign nsize     = h_ff.size - {1'b0, req_ff} - 13'(HEADER_BYTES);
   assign n         = {4'b0, c_ff} + 16'(HEADER_BYTES) + {1'b0, size_ff};
   assign n2        = n + 16'(HEADER_BYTES) + {3'b0, rd_ff.size};
   assign size_b    = size_ff + 15'(HEADER_BYTES) + {2'b0, rd_ff.size};
   assign size_n    = size_b;
   assign sat       = (size_ff > 15'(HEAP_BYTES)) ? 13'(HEAP_BYTES) : size_ff[12:0];
   assign init_size = (initial_free_size > 12'(INIT_CAP)) ? 13'(INIT_CAP)
                                                           : {1'b0, initial_free_size};

   assign sts.op        = op_ff;
   assign sts.c_out     = c_out_ff;
   assign sts.p_out     = p_ff >= 14'(HEAP_BYTES);
   assign sts.hit       = !rd_ff.alloc && (rd_ff.size >= {1'b0, req_ff});
   assign sts.rd_more   = rd_ff.more;
   assign sts.rd_alloc  = rd_ff.alloc;
   assign sts.rd_linked = rd_ff.linked;
   assign sts.split_ok  = ({1'b0, rd_ff.size} >=
                           14'(HEADER_BYTES + MIN_SPLIT_BYTES) + {2'b0, req_ff})
                          && (q < 14'(HEAP_BYTES));
   assign sts.tfix      = h_ff.more && (t < 14'(HEAP_BYTES));
   assign sts.more_r    = more_ff;
   assign sts.n_in      = n < 16'(HEAP_BYTES);
   assign sts.n2_in     = n2 < 16'(HEAP_BYTES);
   assign sts.clr_last  = &clr_ff;

   always_comb begin
      raddr = p_ff[11:0];
      case (cmd.step)
         ST_L_RD:  raddr = naddr_ff;
         ST_R_RDC: raddr = c_ff;
         ST_R_RDB: raddr = lk_ff;
         ST_R_NXT: raddr = n[11:0];
         default:  raddr = p_ff[11:0];
      endcase
   end

   always_comb begin
      waddr = c_ff;
      wdata = '0;
      case (cmd.step)
         ST_CLR: begin
            waddr = clr_ff;
         end
         ST_INIT: begin
            waddr      = '0;
            wdata.size = init_size;
         end
         ST_A_WQ: begin
            waddr = q[11:0];
            wdata = '{link: p_ff[11:0], linked: 1'b1, alloc: 1'b0,
                      more: h_ff.more, size: nsize};
         end
         ST_A_WP: begin
            waddr       = p_ff[11:0];
            wdata       = h_ff;
            wdata.alloc = 1'b1;
            if (split_ff) begin
               wdata.more = 1'b1;
               wdata.size = {1'b0, req_ff};
            end
         end
         ST_L_WR: begin
            waddr        = naddr_ff;
            wdata        = rd_ff;
            wdata.link   = lnk_to_ff;
            wdata.linked = 1'b1;
         end
         ST_R_WC: begin
            waddr = c_ff;
            wdata = '{link: lk_ff, linked: lkd_ff, alloc: 1'b0, more: more_ff, size: sat};
         end
         default: begin
            waddr = c_ff;
            wdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) mem[waddr] <= wdata;
      if (cmd.mem_rd) rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      clr_ff <= (cmd.step == ST_CLR) ? clr_ff + 12'd1 : '0;
      if (cmd.rsp_load) rsp_ff <= '{payload_address: addr_ff, granted: grant_ff};
      case (cmd.step)
         ST_IDLE: begin
            op_ff    <= req_data.operation;
            req_ff   <= req_data.request_size;
            c_ff     <= c32[11:0];
            c_out_ff <= |c32[31:12];
            p_ff     <= '0;
            split_ff <= 1'b0;
         end
         ST_A_CHK: begin
            h_ff <= rd_ff;
            if (!sts.hit) p_ff <= p_ff + 14'(HEADER_BYTES) + {1'b0, rd_ff.size};
         end
         ST_A_WQ: begin
            split_ff  <= 1'b1;
            naddr_ff  <= t[11:0];
            lnk_to_ff <= q[11:0];
         end
         ST_A_WP: begin
            addr_ff  <= base_address + {18'b0, p_ff} + 32'(HEADER_BYTES);
            grant_ff <= 1'b1;
         end
         ST_R_CHC: begin
            size_ff <= {2'b0, rd_ff.size};
            more_ff <= rd_ff.more;
            lk_ff   <= rd_ff.link;
            lkd_ff  <= rd_ff.linked;
         end
         ST_R_CHB: begin
            if (!rd_ff.alloc) begin
               size_ff <= size_b;
               c_ff    <= lk_ff;
               lk_ff   <= rd_ff.link;
               lkd_ff  <= rd_ff.linked;
            end
         end
         ST_R_NXT: begin
            naddr_ff  <= n[11:0];
            lnk_to_ff <= c_ff;
            if (!sts.n_in) more_ff <= 1'b0;
         end
         ST_R_CHN: begin
            if (!rd_ff.alloc) begin
               size_ff <= size_n;
               more_ff <= rd_ff.more;
               if (rd_ff.more) naddr_ff <= n2[11:0];
            end
         end
         ST_R_WC: begin
            addr_ff  <= '0;
            grant_ff <= 1'b1;
         end
         ST_FAIL: begin
            addr_ff  <= '0;
            grant_ff <= 1'b0;
         end
         default: begin
            grant_ff <= grant_ff;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import ffha_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [31:0] link;
      bit          linked;
      bit          alloc;
      bit          more;
      int unsigned size;
   } chunk_type;

   typedef struct {
      logic        op;
      logic [11:0] req_size;
      logic [31:0] rel_addr;
      bit          typed;
      rsp_type     want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   first_fit_heap_allocator_top uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow heap
   chunk_type   heap_map[HEAP_BYTES];
   bit          hdr_known[HEAP_BYTES];
   chunk_type   snap_map[HEAP_BYTES];
   bit          snap_known[HEAP_BYTES];
   bit          undef_touch;
   logic [31:0] heap_base = 32'd0;
   logic [11:0] init_free = 12'd4080;
   logic [31:0] live_addr[$];
   logic [31:0] snap_live[$];
   rsp_type     grant_q[$];
   int          err_cnt = 0;
   int          idle_cnt = 0;
   bit          calm = 1'b0;
   bit          long_hold = 1'b0;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      err_cnt++;
   endtask

   function automatic void heap_rebuild(bit all_known);
      for (int i = 0; i < HEAP_BYTES; i++) begin
         heap_map[i] = '{default: 0};
         hdr_known[i] = all_known;
      end
      heap_map[0].size = (init_free > INIT_CAP) ? INIT_CAP : init_free;
      hdr_known[0] = 1'b1;
      live_addr.delete();
   endfunction

   function automatic chunk_type read_hdr(int unsigned a);
      if (!hdr_known[a]) undef_touch = 1'b1;
      return heap_map[a];
   endfunction

   function automatic void set_link(int unsigned at, int unsigned to);
      if (at < HEAP_BYTES) begin
         heap_map[at].link = to;
         heap_map[at].linked = 1'b1;
      end
   endfunction

   function automatic rsp_type heap_serve(req_type r);
      rsp_type     res;
      chunk_type   h, n, hb, hn;
      int unsigned p, q, sz, nx, b;
      logic [31:0] c32;
      bit          done, found, more;
      res = '0;
      if (r.operation == OP_ALLOC) begin
         p = 0;
         done = 0;
         found = 0;
         while (!done) begin
            if (p >= HEAP_BYTES) done = 1;
            else begin
               h = read_hdr(p);
               if (!h.alloc && h.size >= r.request_size) begin
                  found = 1;
                  done = 1;
               end else if (!h.more) done = 1;
               else p = p + HEADER_BYTES + h.size;
            end
         end
         if (found) begin
            h = heap_map[p];
            if (h.size >= HEADER_BYTES + r.request_size + MIN_SPLIT_BYTES) begin
               q = p + HEADER_BYTES + r.request_size;
               if (q < HEAP_BYTES) begin
                  n.link = p;
                  n.linked = 1;
                  n.alloc = 0;
                  n.more = h.more;
                  n.size = h.size - r.request_size - HEADER_BYTES;
                  heap_map[q] = n;
                  hdr_known[q] = 1'b1;
                  if (n.more) set_link(q + HEADER_BYTES + n.size, q);
                  h.size = r.request_size;
                  h.more = 1;
               end
            end
            h.alloc = 1;
            heap_map[p] = h;
            res.payload_address = heap_base + p + HEADER_BYTES;
            res.granted = 1'b1;
         end
      end else begin
         c32 = r.release_address - heap_base - HEADER_BYTES;
         if (c32 < HEAP_BYTES) begin
            p = c32;
            h = read_hdr(p);
            sz = h.size;
            more = h.more;
            if (h.linked && h.link < HEAP_BYTES) begin
               b = h.link;
               hb = read_hdr(b);
               if (!hb.alloc) begin
                  sz += HEADER_BYTES + hb.size;
                  p = b;
               end
            end
            if (more) begin
               nx = p + HEADER_BYTES + sz;
               if (nx < HEAP_BYTES) begin
                  hn = read_hdr(nx);
                  if (!hn.alloc) begin
                     sz += HEADER_BYTES + hn.size;
                     more = hn.more;
                     if (more) nx = p + HEADER_BYTES + sz;
                  end
                  set_link(nx, p);
               end else more = 0;
            end
            heap_map[p].size = (sz > HEAP_BYTES) ? HEAP_BYTES : sz;
            heap_map[p].more = more;
            heap_map[p].alloc = 0;
            res.granted = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic req_type pick_request(output int live_idx);
      req_type     r;
      int unsigned k, off;
      r = '0;
      live_idx = -1;
      k = $urandom_range(0, 99);
      if (k < 45) begin
         r.operation = OP_ALLOC;
         r.request_size = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 256));
      end else if (k < 85 && live_addr.size() > 0) begin
         r.operation = OP_RELEASE;
         live_idx = $urandom_range(0, live_addr.size() - 1);
         r.release_address = live_addr[live_idx];
      end else if (k < 92) begin
         r.operation = OP_RELEASE;
         r.request_size = 12'($urandom);
         do r.release_address = $urandom;
         while (r.release_address - heap_base - HEADER_BYTES < HEAP_BYTES);
      end else begin
         r.operation = OP_RELEASE;
         r.request_size = 12'($urandom);
         do off = $urandom_range(0, HEAP_BYTES - 1);
         while (!hdr_known[off]);
         r.release_address = heap_base + off + HEADER_BYTES;
      end
      return r;
   endfunction

   task automatic send_item(req_type r, rsp_type e);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      grant_q.push_back(e);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_random(int count);
      req_type r;
      rsp_type e;
      int      idx;
      bit      ok;
      for (int i = 0; i < count; i++) begin
         ok = 0;
         for (int t = 0; t < 20 && !ok; t++) begin
            snap_map = heap_map;
            snap_known = hdr_known;
            snap_live = live_addr;
            undef_touch = 0;
            r = pick_request(idx);
            e = heap_serve(r);
            if (undef_touch) begin
               heap_map = snap_map;
               hdr_known = snap_known;
               live_addr = snap_live;
            end else ok = 1;
         end
         if (!ok) begin
            r = '0;
            r.operation = OP_RELEASE;
            r.release_address = heap_base;
            e = heap_serve(r);
         end else if (idx >= 0) live_addr.delete(idx);
         if (r.operation == OP_ALLOC && e.granted) live_addr.push_back(e.payload_address);
         send_item(r, e);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] d);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == {CSR_BASE_ADDRESS, 2'b00}) heap_base = d;
      else init_free = d[11:0];
      heap_rebuild(1'b1);
   endtask

   task automatic configure(logic [31:0] base, logic [11:0] init_sz);
      drain();
      csr_write({CSR_BASE_ADDRESS, 2'b00}, base);
      csr_write({CSR_INITIAL_FREE_SIZE, 2'b00}, {20'($urandom), init_sz});
      @(posedge clock);
   endtask

   // receiver stall pattern
   initial begin
      int  n;
      bit  v;
      forever begin
         if (calm) begin
            @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (long_hold) begin
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else begin
            n = $urandom_range(1, 19);
            v = ($urandom_range(0, 2) == 0);
            @(posedge clock);
            rsp_stall <= v;
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   // result checking and watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable))
            idle_cnt <= 0;
         else
            idle_cnt <= idle_cnt + 1;
         if (rsp_valid && !rsp_stall) begin
            if (grant_q.size() == 0)
               report_mismatch("unexpected transaction", rsp_data.payload_address, 32'd0);
            else begin
               want = grant_q.pop_front();
               if (rsp_data.payload_address !== want.payload_address)
                  report_mismatch("payload_address", rsp_data.payload_address,
                                  want.payload_address);
               if (rsp_data.granted !== want.granted)
                  report_mismatch("granted", {31'b0, rsp_data.granted},
                                  {31'b0, want.granted});
            end
         end
         if (idle_cnt >= IDLE_LIMIT) begin
            $display("first_fit_heap_allocator_top verification failed");
            $finish;
         end
      end
   end

   dir_row_type dir_rows[19];

   initial begin
      rsp_type e;
      req_type r;
      dir_rows[0]  = '{OP_ALLOC,   12'd0,    32'h0,        1, '{32'd16, 1'b1}};
      dir_rows[1]  = '{OP_ALLOC,   12'd4080, 32'h0,        1, '{32'd0,  1'b0}};
      dir_rows[2]  = '{OP_ALLOC,   12'd4064, 32'h0,        1, '{32'd32, 1'b1}};
      dir_rows[3]  = '{OP_ALLOC,   12'd1,    32'h0,        1, '{32'd0,  1'b0}};
      dir_rows[4]  = '{OP_RELEASE, 12'd0,    32'd32,       1, '{32'd0,  1'b1}};
      dir_rows[5]  = '{OP_RELEASE, 12'hFFF,  32'd16,       1, '{32'd0,  1'b1}};
      dir_rows[6]  = '{OP_ALLOC,   12'd4080, 32'hFFFFFFFF, 1, '{32'd16, 1'b1}};
      dir_rows[7]  = '{OP_RELEASE, 12'd0,    32'd16,       1, '{32'd0,  1'b1}};
      dir_rows[8]  = '{OP_RELEASE, 12'd0,    32'hFFFFFFFF, 1, '{32'd0,  1'b0}};
      dir_rows[9]  = '{OP_RELEASE, 12'd0,    32'h0,        1, '{32'd0,  1'b0}};
      dir_rows[10] = '{OP_ALLOC,   12'hFFF,  32'h0,        1, '{32'd0,  1'b0}};
      dir_rows[11] = '{OP_ALLOC,   12'd100,  32'h0,        0, '0};
      dir_rows[12] = '{OP_ALLOC,   12'd200,  32'h0,        0, '0};
      dir_rows[13] = '{OP_ALLOC,   12'd50,   32'h0,        0, '0};
      dir_rows[14] = '{OP_RELEASE, 12'd0,    32'd132,      0, '0};
      dir_rows[15] = '{OP_RELEASE, 12'd0,    32'd16,       0, '0};
      dir_rows[16] = '{OP_RELEASE, 12'd0,    32'd348,      0, '0};
      dir_rows[17] = '{OP_ALLOC,   12'd4080, 32'h0,        0, '0};
      dir_rows[18] = '{OP_RELEASE, 12'd0,    32'h00001010, 1, '{32'd0,  1'b0}};
      heap_rebuild(1'b0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         r = '0;
         r.operation = dir_rows[i].op;
         r.request_size = dir_rows[i].req_size;
         r.release_address = dir_rows[i].rel_addr;
         e = heap_serve(r);
         send_item(r, dir_rows[i].typed ? dir_rows[i].want : e);
      end
      live_addr.delete();
      send_random(150);
      configure(32'hFFFFFFF0, 12'd4080);
      send_random(60);
      long_hold = 1'b1;
      send_random(110);
      configure(32'h00000000, 12'd0);
      send_random(60);
      configure($urandom, 12'hFFF);
      send_random(200);
      configure($urandom, 12'($urandom_range(16, 4080)));
      send_random(200);
      configure(32'hFFFFFFFF, 12'd300);
      calm = 1'b1;
      send_random(150);
      req_valid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (err_cnt == 0)
         $display("first_fit_heap_allocator_top verification clean");
      else
         $display("first_fit_heap_allocator_top verification failed");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/ffha_dp.sv
hw/rtl/first_fit_heap_allocator_top.sv
tb/tb_top.sv
